@@ rtl/dtfp_pkg.sv @@
package dtfp_pkg;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SIGN,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_DOTS    = 3'd2,
      ST_INVALID = 3'd3,
      ST_FRAC    = 3'd4,
      ST_DIGITS  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SC_ONE,
      SC_TEN,
      SC_HUNDRED
   } scale_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [4:0] DIGIT_SAT  = 5'd21;
   localparam logic [4:0] DIGIT_MAX  = 5'd20;
   localparam logic [1:0] FRAC_SAT   = 2'd3;
   localparam logic [1:0] FRAC_MAX   = 2'd2;

   // Everything the result stage needs once the string has ended.
   typedef struct packed {
      logic [63:0] accumulator;
      logic        negative;
      scale_type   scale;
      status_type  status;
   } summary_type;

endpackage

@@ rtl/dtfp_req_if.sv @@
interface dtfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       has_char;
   logic       last;

   modport source (output valid, output char_code, output has_char, output last,
                   input ready);
   modport sink (input valid, input char_code, input has_char, input last,
                 output ready);
endinterface

@@ rtl/dtfp_rsp_if.sv @@
interface dtfp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] scaled_value;
   logic [2:0]         status;

   modport source (output valid, output scaled_value, output status, input ready);
   modport sink (input valid, input scaled_value, input status, output ready);
endinterface

@@ rtl/dtfp_char_parser.sv @@
module dtfp_char_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          char_code,
   input  logic                has_char,
   input  logic                last,
   output dtfp_pkg::summary_type summary
);

   dtfp_pkg::phase_type  phase_ff, phase_in;
   logic                 negative_ff, negative_in;
   logic [63:0]          acc_ff, acc_in;
   logic [4:0]           digits_ff, digits_in;
   logic [1:0]           frac_ff, frac_in;
   logic                 dot_ff, dot_in;
   logic                 space_ff, space_in;
   dtfp_pkg::status_type error_ff, error_in;
   logic [3:0]           digit_value;
   logic                 is_digit;

   assign digit_value = 4'(char_code - dtfp_pkg::CHAR_ZERO);
   assign is_digit    = (char_code >= dtfp_pkg::CHAR_ZERO) &&
                        (char_code <= dtfp_pkg::CHAR_NINE);

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      digits_in   = digits_ff;
      frac_in     = frac_ff;
      dot_in      = dot_ff;
      space_in    = space_ff;
      error_in    = error_ff;
      // Once an error is held, later characters leave the state alone.
      if (has_char && (error_ff == dtfp_pkg::ST_OK)) begin
         if (char_code == dtfp_pkg::CHAR_SPACE) begin
            if (phase_ff != dtfp_pkg::PH_LEAD) begin
               space_in = 1'b1;
            end
         end else if (space_ff) begin
            error_in = dtfp_pkg::ST_INVALID;
         end else if ((phase_ff == dtfp_pkg::PH_LEAD) &&
                      (char_code == dtfp_pkg::CHAR_MINUS)) begin
            negative_in = 1'b1;
            phase_in    = dtfp_pkg::PH_SIGN;
         end else if ((phase_ff == dtfp_pkg::PH_LEAD) &&
                      (char_code == dtfp_pkg::CHAR_PLUS)) begin
            phase_in = dtfp_pkg::PH_SIGN;
         end else begin
            phase_in = dtfp_pkg::PH_BODY;
            if (is_digit) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + {60'd0, digit_value};
               if (digits_ff < dtfp_pkg::DIGIT_SAT) begin
                  digits_in = digits_ff + 5'd1;
               end
               if (dot_ff && (frac_ff < dtfp_pkg::FRAC_SAT)) begin
                  frac_in = frac_ff + 2'd1;
               end
            end else if (char_code == dtfp_pkg::CHAR_DOT) begin
               if (dot_ff) begin
                  error_in = dtfp_pkg::ST_DOTS;
               end else begin
                  dot_in = 1'b1;
               end
            end else begin
               error_in = dtfp_pkg::ST_INVALID;
            end
         end
      end
   end

   always_comb begin
      summary.accumulator = acc_in;
      summary.negative    = negative_in;
      if (error_in != dtfp_pkg::ST_OK) begin
         summary.status = error_in;
      end else if (phase_in != dtfp_pkg::PH_BODY) begin
         summary.status = dtfp_pkg::ST_EMPTY;
      end else if (dot_in && (frac_in > dtfp_pkg::FRAC_MAX)) begin
         summary.status = dtfp_pkg::ST_FRAC;
      end else if (digits_in > dtfp_pkg::DIGIT_MAX) begin
         summary.status = dtfp_pkg::ST_DIGITS;
      end else begin
         summary.status = dtfp_pkg::ST_OK;
      end
      if (!dot_in || (frac_in == 2'd0)) begin
         summary.scale = dtfp_pkg::SC_HUNDRED;
      end else if (frac_in == 2'd1) begin
         summary.scale = dtfp_pkg::SC_TEN;
      end else begin
         summary.scale = dtfp_pkg::SC_ONE;
      end
   end

   // The final request of a string hands its summary on and clears the state.
   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         phase_ff    <= dtfp_pkg::PH_LEAD;
         negative_ff <= 1'b0;
         acc_ff      <= 64'd0;
         digits_ff   <= 5'd0;
         frac_ff     <= 2'd0;
         dot_ff      <= 1'b0;
         space_ff    <= 1'b0;
         error_ff    <= dtfp_pkg::ST_OK;
      end else if (take) begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
         digits_ff   <= digits_in;
         frac_ff     <= frac_in;
         dot_ff      <= dot_in;
         space_ff    <= space_in;
         error_ff    <= error_in;
      end
   end

endmodule

@@ rtl/decimal_text_to_fixed_point.sv @@
// Decimal text to fixed point, scale 100.
// The req channel carries one byte of a decimal text field per request, with
// has_char marking a real character and last marking the end of the string.
// A request with last and no character ends the string without adding a character.
// For each request with last, the rsp channel gives one result: the number
// times 100 as a signed 64-bit value, and a status code (zero value on error).
// Requests without last update the parse state and produce nothing.
// After its last request is accepted, the result of a string goes through a scaling
// stage, then the output register.
// Throughput: one request per cycle while req.ready is high; each byte costs one
// shift-add on the 64-bit accumulator, and the scaling stage one constant multiply.
// When the receiver stalls, the result is held in the output register and the
// scaling stage takes one more; only when both are full does req.ready drop.
// Reset is synchronous and clears the parse state and both stages.
module decimal_text_to_fixed_point (
   input logic  clock,
   input logic  reset,
   dtfp_req_if.sink   req,
   dtfp_rsp_if.source rsp
);

   dtfp_pkg::summary_type summary;
   logic                  take;
   logic                  out_load;
   logic                  stage_load;

   logic                  stage_valid_ff;
   dtfp_pkg::summary_type stage_ff;
   logic [63:0]           scaled_in;

   logic                  out_valid_ff;
   logic signed [63:0]    out_value_ff, out_value_in;
   dtfp_pkg::status_type  out_status_ff;

   assign out_load   = !out_valid_ff || rsp.ready;
   assign stage_load = !stage_valid_ff || out_load;
   assign req.ready  = stage_load;
   assign take       = req.valid && req.ready;

   dtfp_char_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req.char_code),
      .has_char  (req.has_char),
      .last      (req.last),
      .summary   (summary)
   );

   always_comb begin
      case (stage_ff.scale)
         dtfp_pkg::SC_HUNDRED: scaled_in = (stage_ff.accumulator << 6) +
                                           (stage_ff.accumulator << 5) +
                                           (stage_ff.accumulator << 2);
         dtfp_pkg::SC_TEN:     scaled_in = (stage_ff.accumulator << 3) +
                                           (stage_ff.accumulator << 1);
         default:              scaled_in = stage_ff.accumulator;
      endcase
      if (stage_ff.status != dtfp_pkg::ST_OK) begin
         out_value_in = 64'sd0;
      end else if (stage_ff.negative) begin
         out_value_in = $signed(64'd0 - scaled_in);
      end else begin
         out_value_in = $signed(scaled_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_load) begin
         stage_valid_ff <= take && req.last;
      end
      if (stage_load && take && req.last) begin
         stage_ff <= summary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= stage_valid_ff;
      end
      if (out_load && stage_valid_ff) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= stage_ff.status;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.scaled_value = out_value_ff;
   assign rsp.status       = out_status_ff;

endmodule

@@ bench/tb_decimal_text_to_fixed_point.sv @@
module tb_decimal_text_to_fixed_point;

   localparam int RANDOM_TEXT_BYTES = 650;
   localparam int PHASE_BYTES       = 130;
   localparam int STALL_LIMIT       = 2000;
   localparam int DRAIN_CYCLES      = 4;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic [7:0]    char_code;
      logic          has_char;
      logic          last;
      idle_mode_type mode;
   } pending_request_type;

   typedef struct {
      logic signed [63:0]   value;
      dtfp_pkg::status_type status;
   } fixed_result_type;

   logic clock = 1'b0;
   logic reset;

   dtfp_req_if req_bus ();
   dtfp_rsp_if rsp_bus ();

   decimal_text_to_fixed_point dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pending_request_type pending_requests [$];
   fixed_result_type    expected_results [$];
   pending_request_type next_request;
   fixed_result_type    oldest_result;
   idle_mode_type       active_mode = IDLE_NONE;
   int                  text_bytes_queued = 0;
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;

   // Parse state of the predictor.
   dtfp_pkg::phase_type  parse_phase;
   logic                 parse_negative;
   logic [63:0]          parse_acc;
   logic [4:0]           parse_digits;
   logic [1:0]           parse_frac;
   logic                 parse_dot;
   logic                 parse_space;
   dtfp_pkg::status_type parse_error;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_parse_state();
      parse_phase    = dtfp_pkg::PH_LEAD;
      parse_negative = 1'b0;
      parse_acc      = 64'd0;
      parse_digits   = 5'd0;
      parse_frac     = 2'd0;
      parse_dot      = 1'b0;
      parse_space    = 1'b0;
      parse_error    = dtfp_pkg::ST_OK;
   endtask

   task automatic take_text_byte(input logic [7:0] code);
      // Once an error has been seen, nothing changes until the string ends.
      if (parse_error == dtfp_pkg::ST_OK) begin
         if (code == dtfp_pkg::CHAR_SPACE) begin
            if (parse_phase != dtfp_pkg::PH_LEAD) parse_space = 1'b1;
         end else if (parse_space) begin
            parse_error = dtfp_pkg::ST_INVALID;
         end else if (parse_phase == dtfp_pkg::PH_LEAD && code == dtfp_pkg::CHAR_MINUS) begin
            parse_negative = 1'b1;
            parse_phase    = dtfp_pkg::PH_SIGN;
         end else if (parse_phase == dtfp_pkg::PH_LEAD && code == dtfp_pkg::CHAR_PLUS) begin
            parse_phase = dtfp_pkg::PH_SIGN;
         end else begin
            parse_phase = dtfp_pkg::PH_BODY;
            if (code >= dtfp_pkg::CHAR_ZERO && code <= dtfp_pkg::CHAR_NINE) begin
               parse_acc = parse_acc * 64'd10 + 64'(code - dtfp_pkg::CHAR_ZERO);
               if (parse_digits < dtfp_pkg::DIGIT_SAT)
                  parse_digits = parse_digits + 5'd1;
               if (parse_dot && parse_frac < dtfp_pkg::FRAC_SAT)
                  parse_frac = parse_frac + 2'd1;
            end else if (code == dtfp_pkg::CHAR_DOT) begin
               if (parse_dot) parse_error = dtfp_pkg::ST_DOTS;
               else parse_dot = 1'b1;
            end else begin
               parse_error = dtfp_pkg::ST_INVALID;
            end
         end
      end
   endtask

   task automatic predict_request(input logic [7:0] code, input logic has, input logic fin);
      fixed_result_type result;
      logic [63:0] scaled;
      if (has) take_text_byte(code);
      if (fin) begin
         if (parse_error != dtfp_pkg::ST_OK)
            result.status = parse_error;
         else if (parse_phase != dtfp_pkg::PH_BODY)
            result.status = dtfp_pkg::ST_EMPTY;
         else if (parse_dot && parse_frac > dtfp_pkg::FRAC_MAX)
            result.status = dtfp_pkg::ST_FRAC;
         else if (parse_digits > dtfp_pkg::DIGIT_MAX)
            result.status = dtfp_pkg::ST_DIGITS;
         else
            result.status = dtfp_pkg::ST_OK;
         scaled = 64'd0;
         if (result.status == dtfp_pkg::ST_OK) begin
            scaled = parse_acc;
            if (!parse_dot || parse_frac == 2'd0) scaled = scaled * 64'd100;
            else if (parse_frac == 2'd1) scaled = scaled * 64'd10;
            if (parse_negative) scaled = -scaled;
         end
         result.value = scaled;
         expected_results.push_back(result);
         clear_parse_state();
      end
   endtask

   function automatic logic idle_roll(input logic sender_side, input idle_mode_type mode);
      int percent;
      case (mode)
         IDLE_SEND: percent = sender_side ? 55 : 0;
         IDLE_RECV: percent = sender_side ? 0 : 55;
         IDLE_BOTH: percent = 11;
         default:   percent = 0;
      endcase
      return $urandom_range(99) < percent;
   endfunction

   task automatic queue_byte(input logic [7:0] code, input logic has, input logic fin,
                             input idle_mode_type mode);
      pending_request_type item;
      item.char_code = code;
      item.has_char  = has;
      item.last      = fin;
      item.mode      = mode;
      pending_requests.push_back(item);
      if (has) text_bytes_queued++;
   endtask

   task automatic queue_text(input string text);
      for (int i = 0; i < text.len(); i++)
         queue_byte(text[i], 1'b1, i == text.len() - 1, IDLE_NONE);
   endtask

   task automatic queue_random_string(input idle_mode_type mode);
      logic [7:0] text [$];
      logic [7:0] odd_byte;
      int kind;
      int pick;
      int pos;
      logic blank_end;
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 2)) text.push_back(dtfp_pkg::CHAR_SPACE);
         case ($urandom_range(2))
            0: text.push_back(dtfp_pkg::CHAR_MINUS);
            1: text.push_back(dtfp_pkg::CHAR_PLUS);
            default: ;
         endcase
         pick = $urandom_range(99);
         if (pick < 8) pick = 0;
         else if (pick < 85) pick = $urandom_range(1, 6);
         else pick = $urandom_range(17, 23);
         repeat (pick) text.push_back(dtfp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         if ($urandom_range(1) == 1) begin
            text.push_back(dtfp_pkg::CHAR_DOT);
            repeat ($urandom_range(0, 3))
               text.push_back(dtfp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         end
         repeat ($urandom_range(0, 2)) text.push_back(dtfp_pkg::CHAR_SPACE);
         // A fifth of the strings get one stray character somewhere.
         if (kind < 32) begin
            case ($urandom_range(4))
               0: odd_byte = dtfp_pkg::CHAR_SPACE;
               1: odd_byte = dtfp_pkg::CHAR_DOT;
               2: odd_byte = dtfp_pkg::CHAR_PLUS;
               3: odd_byte = dtfp_pkg::CHAR_MINUS;
               default: odd_byte = 8'($urandom_range(255));
            endcase
            pos = $urandom_range(text.size());
            if (pos == text.size()) text.push_back(odd_byte);
            else if ($urandom_range(1) == 1) text[pos] = odd_byte;
            else text.insert(pos, odd_byte);
         end
      end
      blank_end = ($urandom_range(9) == 0) || (text.size() == 0);
      foreach (text[i]) begin
         if ($urandom_range(19) == 0) queue_byte(8'($urandom_range(255)), 1'b0, 1'b0, mode);
         queue_byte(text[i], 1'b1, !blank_end && i == text.size() - 1, mode);
      end
      if (blank_end) queue_byte(8'($urandom_range(255)), 1'b0, 1'b1, mode);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_request(req_bus.char_code, req_bus.has_char, req_bus.last);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && !idle_roll(1'b1, pending_requests[0].mode)) begin
               next_request = pending_requests.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.char_code <= next_request.char_code;
               req_bus.has_char  <= next_request.has_char;
               req_bus.last      <= next_request.last;
               active_mode       <= next_request.mode;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_bus.scaled_value, 64'd0);
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_bus.scaled_value !== oldest_result.value)
                  report_mismatch("scaled_value", rsp_bus.scaled_value, oldest_result.value);
               if (rsp_bus.status !== oldest_result.status)
                  report_mismatch("status", 64'(rsp_bus.status), 64'(oldest_result.status));
            end
         end
         rsp_bus.ready <= !idle_roll(1'b0, active_mode);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      idle_mode_type mode;
      int random_start;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = 8'd0;
      req_bus.has_char  = 1'b0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      clear_parse_state();

      // Directed strings: empty, lone dot, sign only, trimming, errors.
      queue_byte(8'h00, 1'b0, 1'b1, IDLE_NONE);
      queue_text(".");
      queue_text("-.");
      queue_text("-");
      queue_text(" 9 ");
      queue_text("+0.5");
      queue_text("1 2");
      queue_text("1..");
      queue_text("1+");
      queue_text(".123");
      queue_byte(8'hFF, 1'b1, 1'b1, IDLE_NONE);
      queue_byte(8'h00, 1'b1, 1'b1, IDLE_NONE);
      queue_byte(dtfp_pkg::CHAR_ZERO + 8'd1, 1'b1, 1'b0, IDLE_NONE);
      queue_byte(8'hA5, 1'b0, 1'b0, IDLE_NONE);
      queue_byte(8'h5A, 1'b0, 1'b1, IDLE_NONE);

      random_start = text_bytes_queued;
      while (text_bytes_queued - random_start < RANDOM_TEXT_BYTES) begin
         case (((text_bytes_queued - random_start) / PHASE_BYTES) % 5)
            0: mode = IDLE_SEND;
            1: mode = IDLE_RECV;
            2: mode = IDLE_BOTH;
            3: mode = IDLE_NONE;
            default: mode = IDLE_BOTH;
         endcase
         queue_random_string(mode);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never arrived", 64'(expected_results.size()), 64'd0);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
